>>> sv/tcrr_pkg.sv
// ----------------------------------------------------------------------------
// tcrr_pkg
// Shared constants, types and decode functions for the timed command
// record and replay unit.
// ----------------------------------------------------------------------------
package tcrr_pkg;

  // Path store geometry.
  localparam int MAX_SEGMENTS = 256;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DURATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SPEED = 1'd1;
  localparam logic [15:0] MIN_DURATION_RST  = 16'd50;
  localparam logic [7:0]  DEFAULT_SPEED_RST = 8'd150;

  // Request types.
  localparam logic [2:0] REQ_TEACH_START  = 3'd0;
  localparam logic [2:0] REQ_TEACH_CMD    = 3'd1;
  localparam logic [2:0] REQ_TEACH_FINISH = 3'd2;
  localparam logic [2:0] REQ_REPLAY_START = 3'd3;
  localparam logic [2:0] REQ_REPLAY_POLL  = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_NONE        = 3'd0;
  localparam logic [2:0] ST_TEACH_OK    = 3'd1;
  localparam logic [2:0] ST_SAVED       = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_SPEED_SAVED = 3'd4;
  localparam logic [2:0] ST_REPLAY_OK   = 3'd5;
  localparam logic [2:0] ST_EMPTY       = 3'd6;
  localparam logic [2:0] ST_DONE        = 3'd7;

  // Entry kinds and held command codes.
  localparam logic [3:0] KIND_SPEED = 4'd9;
  localparam logic [3:0] HELD_NONE  = 4'd15;
  localparam logic [3:0] DIR_STOP   = 4'd8;
  localparam logic [15:0] HOLD_SAT  = 16'hFFFF;

  // ASCII command bytes.
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_J = 8'h4A;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_1 = 8'h31;
  localparam logic [7:0] CH_9 = 8'h39;

  // One path store entry: movement direction or speed marker, and its value.
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] value;
  } entry_t;

  // Maps a movement byte to its direction code, or HELD_NONE.
  function automatic logic [3:0] move_code(input logic [7:0] c);
    logic [3:0] d;
    unique case (c)
      CH_F:    d = 4'd0;
      CH_B:    d = 4'd1;
      CH_L:    d = 4'd2;
      CH_R:    d = 4'd3;
      CH_G:    d = 4'd4;
      CH_H:    d = 4'd5;
      CH_I:    d = 4'd6;
      CH_J:    d = 4'd7;
      CH_S:    d = DIR_STOP;
      default: d = HELD_NONE;
    endcase
    return d;
  endfunction

  // Speed level table, indexed by digit minus one.
  function automatic logic [7:0] speed_level(input logic [3:0] idx);
    logic [7:0] s;
    unique case (idx)
      4'd0:    s = 8'd80;
      4'd1:    s = 8'd100;
      4'd2:    s = 8'd120;
      4'd3:    s = 8'd140;
      4'd4:    s = 8'd160;
      4'd5:    s = 8'd180;
      4'd6:    s = 8'd200;
      4'd7:    s = 8'd225;
      4'd8:    s = 8'd250;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

>>> sv/timed_command_record_replay_unit.sv
// ----------------------------------------------------------------------------
// timed_command_record_replay_unit
// Records a timed path of drive and speed commands in a path store and
// replays it against a millisecond clock.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its result appears on
// the out_ ports for exactly one cycle, marked by out_strobe; the receiver
// cannot hold it off, and the next item may be taken in that same cycle. Teach
// items, unknown requests, replay start on an empty store, replay polls that
// stay on a movement and polls past the end go from the execute state straight
// to the result. Replay start on a filled store, polls that sit on a speed
// entry and polls that move on to new entries pass through the run state,
// which walks over consecutive speed entries: the path store is read one entry
// per cycle through its single registered read port. There is no clearing
// pass after reset.
module timed_command_record_replay_unit
  import tcrr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input item.
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_req_type,
  input  logic [7:0]            in_cmd_code,
  input  logic [31:0]           in_now_ms,
  // Result item.
  output logic                  out_strobe,
  output logic                  out_drive_valid,
  output logic [3:0]            out_drive_dir,
  output logic                  out_speed_valid,
  output logic [7:0]            out_speed_value,
  output logic [2:0]            out_status,
  output logic [CNT_W-1:0]      out_segment_count,
  output logic                  out_playing,
  // Configuration.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [2:0]       req_r;
  logic [7:0]       cmd_r;
  logic [31:0]      now_r;
  logic [31:0]      hold_diff_r;
  logic [31:0]      phase_diff_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [3:0]       held_r, held_nxt;
  logic [31:0]      hold_start_r, hold_start_nxt;
  logic [CNT_W-1:0] pi_r, pi_nxt;
  logic [31:0]      phase_start_r, phase_start_nxt;
  logic [15:0]      min_dur_r;
  logic [7:0]       def_speed_r;

  logic             strobe_r, strobe_nxt;
  logic             dv_r, dv_nxt;
  logic [3:0]       dir_r, dir_nxt;
  logic             sv_r, sv_nxt;
  logic [7:0]       spd_r, spd_nxt;
  logic [2:0]       st_r, st_nxt;
  logic             play_r, play_nxt;

  // Path store and its port signals.
  entry_t           mem [MAX_SEGMENTS];
  entry_t           rdata_r;
  logic             mem_we;
  entry_t           mem_wdata;

  logic             accept;
  logic             too_short;
  logic             full;
  logic [15:0]      hold_sat;
  logic [3:0]       move_d;
  logic             is_digit;
  logic [7:0]       digit_off;
  logic             entry_live;
  logic [CNT_W-1:0] pi_inc;
  logic             go;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // Decode helpers for the execute step.
  assign too_short  = hold_diff_r < {16'd0, min_dur_r};
  assign full       = count_r >= CNT_W'(MAX_SEGMENTS);
  assign hold_sat   = (|hold_diff_r[31:16]) ? HOLD_SAT : hold_diff_r[15:0];
  assign move_d     = move_code(cmd_r);
  assign is_digit   = (cmd_r >= CH_1) && (cmd_r <= CH_9);
  assign digit_off  = cmd_r - CH_1;
  assign entry_live = pi_r < count_r;
  assign pi_inc     = pi_r + CNT_W'(1);

  // Next-state and result logic.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    held_nxt        = held_r;
    hold_start_nxt  = hold_start_r;
    pi_nxt          = pi_r;
    phase_start_nxt = phase_start_r;
    strobe_nxt      = 1'b0;
    dv_nxt          = dv_r;
    dir_nxt         = dir_r;
    sv_nxt          = sv_r;
    spd_nxt         = spd_r;
    st_nxt          = st_r;
    play_nxt        = play_r;
    mem_we          = 1'b0;
    mem_wdata       = '{kind: held_r, value: hold_sat};
    go              = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          dv_nxt    = 1'b0;
          dir_nxt   = 4'd0;
          sv_nxt    = 1'b0;
          spd_nxt   = 8'd0;
          st_nxt    = ST_NONE;
          play_nxt  = 1'b0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
        unique case (req_r)
          REQ_TEACH_START: begin
            count_nxt      = '0;
            held_nxt       = HELD_NONE;
            hold_start_nxt = now_r;
            dv_nxt         = 1'b1;
            dir_nxt        = DIR_STOP;
            st_nxt         = ST_TEACH_OK;
          end
          REQ_TEACH_CMD: begin
            if (is_digit) begin
              // Speed digit: issue now and, unless the store is full, record as a speed entry.
              sv_nxt  = 1'b1;
              spd_nxt = speed_level(digit_off[3:0]);
              if (full) begin
                st_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = '{kind: KIND_SPEED, value: {8'd0, spd_nxt}};
                count_nxt = count_r + CNT_W'(1);
                st_nxt    = ST_SPEED_SAVED;
              end
            end else if (move_d != HELD_NONE) begin
              // A changed movement closes the one held so far.
              if (held_r != HELD_NONE && held_r != move_d && !too_short) begin
                if (full) begin
                  st_nxt   = ST_FULL;
                  held_nxt = HELD_NONE;
                  go       = 1'b0;
                end else begin
                  mem_we    = 1'b1;
                  count_nxt = count_r + CNT_W'(1);
                  st_nxt    = ST_SAVED;
                end
              end
              if (go) begin
                if (held_r != move_d) begin
                  held_nxt       = move_d;
                  hold_start_nxt = now_r;
                end
                dv_nxt  = 1'b1;
                dir_nxt = move_d;
              end
            end
          end
          REQ_TEACH_FINISH: begin
            if (held_r != HELD_NONE) begin
              if (!too_short) begin
                if (full) begin
                  st_nxt = ST_FULL;
                end else begin
                  mem_we    = 1'b1;
                  count_nxt = count_r + CNT_W'(1);
                  st_nxt    = ST_SAVED;
                end
              end
              held_nxt = HELD_NONE;
            end
          end
          REQ_REPLAY_START: begin
            if (count_r == '0) begin
              st_nxt = ST_EMPTY;
            end else begin
              // Entry zero is read at this edge; the walk starts next cycle.
              sv_nxt          = 1'b1;
              spd_nxt         = def_speed_r;
              dv_nxt          = 1'b1;
              dir_nxt         = DIR_STOP;
              pi_nxt          = '0;
              phase_start_nxt = now_r;
              st_nxt          = ST_REPLAY_OK;
              play_nxt        = 1'b1;
              strobe_nxt      = 1'b0;
              state_nxt       = S_RUN;
            end
          end
          REQ_REPLAY_POLL: begin
            if (!entry_live) begin
              dv_nxt  = 1'b1;
              dir_nxt = DIR_STOP;
              st_nxt  = ST_DONE;
            end else if (rdata_r.kind == KIND_SPEED) begin
              phase_start_nxt = now_r;
              play_nxt        = 1'b1;
              strobe_nxt      = 1'b0;
              state_nxt       = S_RUN;
            end else begin
              play_nxt = 1'b1;
              if (phase_diff_r >= {16'd0, rdata_r.value}) begin
                pi_nxt = pi_inc;
                if (pi_inc >= count_r) begin
                  dv_nxt   = 1'b1;
                  dir_nxt  = DIR_STOP;
                  st_nxt   = ST_DONE;
                  play_nxt = 1'b0;
                end else begin
                  phase_start_nxt = now_r;
                  strobe_nxt      = 1'b0;
                  state_nxt       = S_RUN;
                end
              end
            end
          end
          default: begin
            // Unknown request types leave everything as it is.
          end
        endcase
      end
      S_RUN: begin
        // Apply speed entries one per cycle, then drive the next movement.
        if (entry_live && rdata_r.kind == KIND_SPEED) begin
          sv_nxt  = 1'b1;
          spd_nxt = rdata_r.value[7:0];
          pi_nxt  = pi_inc;
        end else begin
          if (entry_live) begin
            dv_nxt  = 1'b1;
            dir_nxt = rdata_r.kind;
          end
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Path store. The read port follows the next play index, so the registered
  // read data always holds the entry at the current play index. Writes happen
  // only while teaching and land before any later read uses the same entry, so
  // no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= mem_wdata;
    end
    rdata_r <= mem[pi_nxt[IDX_W-1:0]];
  end

  // Item capture and time differences against the stored start times.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r        <= in_req_type;
      cmd_r        <= in_cmd_code;
      now_r        <= in_now_ms;
      hold_diff_r  <= in_now_ms - hold_start_r;
      phase_diff_r <= in_now_ms - phase_start_r;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    dv_r   <= dv_nxt;
    dir_r  <= dir_nxt;
    sv_r   <= sv_nxt;
    spd_r  <= spd_nxt;
    st_r   <= st_nxt;
    play_r <= play_nxt;
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      strobe_r      <= 1'b0;
      count_r       <= '0;
      held_r        <= HELD_NONE;
      hold_start_r  <= '0;
      pi_r          <= '0;
      phase_start_r <= '0;
      min_dur_r     <= MIN_DURATION_RST;
      def_speed_r   <= DEFAULT_SPEED_RST;
    end else begin
      state_r       <= state_nxt;
      strobe_r      <= strobe_nxt;
      count_r       <= count_nxt;
      held_r        <= held_nxt;
      hold_start_r  <= hold_start_nxt;
      pi_r          <= pi_nxt;
      phase_start_r <= phase_start_nxt;
      if (cfg_we && cfg_index == CFG_MIN_DURATION) begin
        min_dur_r <= cfg_wdata[15:0];
      end
      if (cfg_we && cfg_index == CFG_DEFAULT_SPEED) begin
        def_speed_r <= cfg_wdata[7:0];
      end
    end
  end

  assign out_strobe        = strobe_r;
  assign out_drive_valid   = dv_r;
  assign out_drive_dir     = dir_r;
  assign out_speed_valid   = sv_r;
  assign out_speed_value   = spd_r;
  assign out_status        = st_r;
  assign out_segment_count = count_r;
  assign out_playing       = play_r;

  // A result is only shown once the sequencer is back at rest.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> state_r == S_IDLE)
    else $error("result strobe while sequencer busy");

  // The segment count never passes the store depth.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count beyond store depth");

  // An accepted item makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not start work");

  // A result without a drive carries a zero direction.
  a_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_drive_valid) |-> out_drive_dir == 4'd0)
    else $error("direction set without drive valid");

endmodule
